// ===== hw/rtl/spm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spm_pkg
// shared types and constants of the sparse polynomial multiplier
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int unsigned MaxTermsDef = 8;
  localparam int unsigned ExpBitsDef  = 8;

  localparam int unsigned CoeffW    = 16;
  localparam int unsigned ExpInW    = 8;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned SumCoeffW = 40;
  localparam int unsigned SumExpW   = 9;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 56;

  typedef enum logic [1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_MULTIPLY    = 2'd2,
    OP_CLEAR       = 2'd3
  } spm_op_e;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic clear;
    logic mul;
    logic rd_en;
    logic wr_en;
    logic wr_merge;
    logic best_clr;
    logic best_upd;
    logic thresh_rst;
    logic out_load;
    logic out_empty;
    logic out_last;
  } spm_cmd_t;

  typedef struct packed {
    logic same_exp;
    logic better;
  } spm_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sparse_polynomial_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_polynomial_multiply
// multiplies two sparse polynomials held in term stores, emits merged terms
// ----------------------------------------------------------------------------
// input transactions carry an opcode in tuser: load a term of the first or
// second polynomial, multiply, or clear. loads and clear keep the controller idle.
// a multiply walks every term pair through a registered multiplier and a
// linear merge scan of the sum memory, then picks the merged terms out in
// descending exponent order, one full scan of the memory per term, so the
// memory read port sets the rate. the last term carries tlast; with an empty
// operand one term flagged empty is offered, also carrying tlast.
// terms wait in the output register while the receiver stalls; the
// controller holds and takes no new transaction until the multiply ends.
// reset empties both stores and clears the dropped flag; the sum memory
// is not cleared, as only entries written during a multiply are read.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiply import spm_pkg::*; #(
  parameter int unsigned MAX_TERMS = MaxTermsDef,
  parameter int unsigned EXP_BITS  = ExpBitsDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [InDataW-1:0]  s_axis_tdata,  // term_coeff, term_exponent
  input  wire  [1:0]          s_axis_tuser,  // opcode
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // product_coeff, product_exponent
  output logic                m_axis_tlast,  // last_term
  output logic [1:0]          m_axis_tuser   // product_empty, terms_dropped
);

  localparam int unsigned SumDepth = MAX_TERMS * MAX_TERMS;
  localparam int unsigned IdxW     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned TCntW    = $clog2(MAX_TERMS + 1);
  localparam int unsigned SAddrW   = (SumDepth > 1) ? $clog2(SumDepth) : 1;

  spm_cmd_t          cmd;
  spm_status_t       status;
  logic [TCntW-1:0]  first_cnt, second_cnt;
  logic [IdxW-1:0]   idx_first, idx_second;
  logic [SAddrW-1:0] sum_addr;

  spm_ctrl #(
    .MAX_TERMS(MAX_TERMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status),
    .first_cnt_i (first_cnt),
    .second_cnt_i(second_cnt),
    .idx_first_o (idx_first),
    .idx_second_o(idx_second),
    .sum_addr_o  (sum_addr)
  );

  spm_dp #(
    .MAX_TERMS(MAX_TERMS),
    .EXP_BITS (EXP_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_coeff_i  (s_axis_tdata[CoeffW-1:0]),
    .in_exp_i    (s_axis_tdata[CoeffW+ExpInW-1:CoeffW]),
    .idx_first_i (idx_first),
    .idx_second_i(idx_second),
    .sum_addr_i  (sum_addr),
    .first_cnt_o (first_cnt),
    .second_cnt_o(second_cnt),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten while stalled");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("empty product without last marker");

  a_idle_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !cmd.rd_en && !cmd.wr_en && !cmd.out_load)
    else $error("transaction accepted while a multiply is running");

  a_load_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_cnt <= TCntW'(MAX_TERMS) && second_cnt <= TCntW'(MAX_TERMS))
    else $error("term count beyond capacity");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/spm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spm_dp
// datapath: term stores, multiplier, sum memory, selection and output register
// ----------------------------------------------------------------------------
module spm_dp import spm_pkg::*; #(
  parameter int unsigned MAX_TERMS = MaxTermsDef,
  parameter int unsigned EXP_BITS  = ExpBitsDef,
  localparam int unsigned SumDepth = MAX_TERMS * MAX_TERMS,
  localparam int unsigned IdxW     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int unsigned TCntW    = $clog2(MAX_TERMS + 1),
  localparam int unsigned SAddrW   = (SumDepth > 1) ? $clog2(SumDepth) : 1
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  spm_cmd_t            cmd_i,
  output spm_status_t         status_o,
  input  wire  [CoeffW-1:0]   in_coeff_i,
  input  wire  [ExpInW-1:0]   in_exp_i,
  input  wire  [IdxW-1:0]     idx_first_i,
  input  wire  [IdxW-1:0]     idx_second_i,
  input  wire  [SAddrW-1:0]   sum_addr_i,
  output logic [TCntW-1:0]    first_cnt_o,
  output logic [TCntW-1:0]    second_cnt_o,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_last_o,
  output logic [1:0]          out_user_o
);

  localparam int unsigned StExpW = (EXP_BITS < ExpInW) ? EXP_BITS : ExpInW;

  logic signed [CoeffW-1:0]    first_coeff_q  [MAX_TERMS];
  logic        [StExpW-1:0]    first_exp_q    [MAX_TERMS];
  logic signed [CoeffW-1:0]    second_coeff_q [MAX_TERMS];
  logic        [StExpW-1:0]    second_exp_q   [MAX_TERMS];
  logic        [TCntW-1:0]     first_cnt_q, second_cnt_q;
  logic                        dropped_q;

  logic signed [ProdW-1:0]     prod_coeff_q;
  logic        [SumExpW-1:0]   prod_exp_q;

  logic        [SumCoeffW-1:0] sum_coeff_mem [SumDepth];
  logic        [SumExpW-1:0]   sum_exp_mem   [SumDepth];
  logic        [SumCoeffW-1:0] rd_coeff_q;
  logic        [SumExpW-1:0]   rd_exp_q;
  logic        [SumCoeffW-1:0] wr_coeff;
  logic        [SumCoeffW-1:0] prod_ext;

  logic        [SumCoeffW-1:0] best_coeff_q;
  logic        [SumExpW-1:0]   best_exp_q;
  logic                        best_vld_q;
  logic        [SumExpW:0]     thresh_q;

  assign first_cnt_o  = first_cnt_q;
  assign second_cnt_o = second_cnt_q;

  assign prod_ext = SumCoeffW'(prod_coeff_q);
  assign wr_coeff = cmd_i.wr_merge ? rd_coeff_q + prod_ext : prod_ext;

  assign status_o.same_exp = (rd_exp_q == prod_exp_q);
  assign status_o.better   = ({1'b0, rd_exp_q} < thresh_q) &&
                             (!best_vld_q || (rd_exp_q > best_exp_q));

  // term stores and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      dropped_q    <= 1'b0;
    end else if (cmd_i.clear) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      dropped_q    <= 1'b0;
    end else if (cmd_i.load_first) begin
      if (first_cnt_q < TCntW'(MAX_TERMS)) begin
        first_cnt_q <= first_cnt_q + 1'b1;
      end else begin
        dropped_q <= 1'b1;
      end
    end else if (cmd_i.load_second) begin
      if (second_cnt_q < TCntW'(MAX_TERMS)) begin
        second_cnt_q <= second_cnt_q + 1'b1;
      end else begin
        dropped_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_first && (first_cnt_q < TCntW'(MAX_TERMS))) begin
      first_coeff_q[first_cnt_q[IdxW-1:0]] <= in_coeff_i;
      first_exp_q[first_cnt_q[IdxW-1:0]]   <= in_exp_i[StExpW-1:0];
    end
    if (cmd_i.load_second && (second_cnt_q < TCntW'(MAX_TERMS))) begin
      second_coeff_q[second_cnt_q[IdxW-1:0]] <= in_coeff_i;
      second_exp_q[second_cnt_q[IdxW-1:0]]   <= in_exp_i[StExpW-1:0];
    end
    if (cmd_i.mul) begin
      prod_coeff_q <= first_coeff_q[idx_first_i] * second_coeff_q[idx_second_i];
      prod_exp_q   <= SumExpW'(first_exp_q[idx_first_i]) +
                      SumExpW'(second_exp_q[idx_second_i]);
    end
  end

  // sum memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      sum_coeff_mem[sum_addr_i] <= wr_coeff;
      sum_exp_mem[sum_addr_i]   <= prod_exp_q;
    end
    if (cmd_i.rd_en) begin
      rd_coeff_q <= sum_coeff_mem[sum_addr_i];
      rd_exp_q   <= sum_exp_mem[sum_addr_i];
    end
  end

  // selection of the next highest exponent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
      thresh_q   <= '0;
    end else begin
      if (cmd_i.best_clr) begin
        best_vld_q <= 1'b0;
      end else if (cmd_i.best_upd) begin
        best_vld_q <= 1'b1;
      end
      if (cmd_i.thresh_rst) begin
        thresh_q <= {1'b1, {SumExpW{1'b0}}};
      end else if (cmd_i.out_load && !cmd_i.out_empty) begin
        thresh_q <= {1'b0, best_exp_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.best_upd) begin
      best_coeff_q <= rd_coeff_q;
      best_exp_q   <= rd_exp_q;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_empty) begin
        out_data_o <= '0;
        out_last_o <= 1'b1;
      end else begin
        out_data_o <= {{(OutDataW - SumExpW - SumCoeffW){1'b0}}, best_exp_q, best_coeff_q};
        out_last_o <= cmd_i.out_last;
      end
      out_user_o <= {dropped_q, cmd_i.out_empty};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spm_ctrl
// controller: command decode, pair walk, merge scan and ordered emission
// ----------------------------------------------------------------------------
module spm_ctrl import spm_pkg::*; #(
  parameter int unsigned MAX_TERMS = MaxTermsDef,
  localparam int unsigned SumDepth = MAX_TERMS * MAX_TERMS,
  localparam int unsigned IdxW     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int unsigned TCntW    = $clog2(MAX_TERMS + 1),
  localparam int unsigned SAddrW   = (SumDepth > 1) ? $clog2(SumDepth) : 1,
  localparam int unsigned SCntW    = $clog2(SumDepth + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [1:0]        in_op_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output spm_cmd_t          cmd_o,
  input  spm_status_t       status_i,
  input  wire  [TCntW-1:0]  first_cnt_i,
  input  wire  [TCntW-1:0]  second_cnt_i,
  output logic [IdxW-1:0]   idx_first_o,
  output logic [IdxW-1:0]   idx_second_o,
  output logic [SAddrW-1:0] sum_addr_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROD, ST_SCAN_RD, ST_SCAN_CHK, ST_SEL_RD, ST_SEL_CHK, ST_EMIT, ST_EMPTY
  } state_e;

  state_e         state_q;
  logic [IdxW-1:0]  i_q, j_q;
  logic [SCntW-1:0] k_q, n_q, emit_q;
  logic           accept, slot_free, last_j, last_i, emit_last;
  spm_op_e        op;

  assign op           = spm_op_e'(in_op_i);
  assign in_ready_o   = (state_q == ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign slot_free    = !out_valid_o || out_ready_i;
  assign last_j       = (TCntW'(j_q) + 1'b1 == second_cnt_i);
  assign last_i       = (TCntW'(i_q) + 1'b1 == first_cnt_i);
  assign emit_last    = (emit_q + 1'b1 == n_q);
  assign idx_first_o  = i_q;
  assign idx_second_o = j_q;
  assign sum_addr_o   = k_q[SAddrW-1:0];

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD_FIRST:  cmd_o.load_first  = 1'b1;
            OP_LOAD_SECOND: cmd_o.load_second = 1'b1;
            OP_MULTIPLY:    cmd_o.thresh_rst  = 1'b1;
            OP_CLEAR:       cmd_o.clear       = 1'b1;
            default:        cmd_o.clear       = 1'b0;
          endcase
        end
      end
      ST_PROD: cmd_o.mul = 1'b1;
      ST_SCAN_RD: begin
        if (k_q == n_q) begin
          cmd_o.wr_en = 1'b1;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      ST_SCAN_CHK: begin
        cmd_o.wr_en    = status_i.same_exp;
        cmd_o.wr_merge = status_i.same_exp;
      end
      ST_SEL_RD: begin
        cmd_o.best_clr = (k_q == '0);
        cmd_o.rd_en    = (k_q != n_q);
      end
      ST_SEL_CHK: cmd_o.best_upd = status_i.better;
      ST_EMIT: begin
        cmd_o.out_load = slot_free;
        cmd_o.out_last = emit_last;
      end
      ST_EMPTY: begin
        cmd_o.out_load  = slot_free;
        cmd_o.out_empty = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      n_q         <= '0;
      emit_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (op == OP_MULTIPLY)) begin
            i_q    <= '0;
            j_q    <= '0;
            n_q    <= '0;
            emit_q <= '0;
            if ((first_cnt_i == '0) || (second_cnt_i == '0)) begin
              state_q <= ST_EMPTY;
            end else begin
              state_q <= ST_PROD;
            end
          end
        end
        ST_PROD: begin
          k_q     <= '0;
          state_q <= ST_SCAN_RD;
        end
        ST_SCAN_RD, ST_SCAN_CHK: begin
          if ((state_q == ST_SCAN_RD) && (k_q != n_q)) begin
            state_q <= ST_SCAN_CHK;
          end else if ((state_q == ST_SCAN_CHK) && !status_i.same_exp) begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_SCAN_RD;
          end else begin
            if (state_q == ST_SCAN_RD) begin
              n_q <= n_q + 1'b1;
            end
            if (last_j) begin
              j_q <= '0;
              if (last_i) begin
                k_q     <= '0;
                state_q <= ST_SEL_RD;
              end else begin
                i_q     <= i_q + 1'b1;
                state_q <= ST_PROD;
              end
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= ST_PROD;
            end
          end
        end
        ST_SEL_RD: begin
          state_q <= (k_q == n_q) ? ST_EMIT : ST_SEL_CHK;
        end
        ST_SEL_CHK: begin
          k_q     <= k_q + 1'b1;
          state_q <= ST_SEL_RD;
        end
        ST_EMIT: begin
          if (slot_free) begin
            emit_q <= emit_q + 1'b1;
            k_q    <= '0;
            state_q <= emit_last ? ST_IDLE : ST_SEL_RD;
          end
        end
        ST_EMPTY: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives load, multiply and clear transactions into the sparse polynomial
// multiplier, predicts every emitted term and compares it field by field
// ----------------------------------------------------------------------------
module tb_top;
  import spm_pkg::*;

  typedef struct {
    logic signed [39:0] coeff;
    logic [8:0]         exponent;
    logic               last;
    logic               empty;
    logic               dropped;
  } term_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = OP_CLEAR;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [1:0] m_axis_tuser;

  always #1 clk_i = ~clk_i;

  sparse_polynomial_multiply u_dut (.*);

  // shadow of the term stores
  logic signed [15:0] a_coeff[8], b_coeff[8];
  logic [7:0] a_exp[8], b_exp[8];
  int a_cnt, b_cnt;
  bit dropped_q;
  term_t pending_terms[$];
  int errors, mismatches;
  bit gaps_on = 1'b1, hold_sink = 1'b0;

  task automatic predict(input spm_op_e op, input logic signed [15:0] c, input logic [7:0] e);
    logic signed [39:0] sc[$];
    logic [8:0] se[$];
    logic [8:0] pe;
    logic signed [39:0] pc;
    int pos;
    term_t t;
    case (op)
      OP_LOAD_FIRST: begin
        if (a_cnt >= 8) dropped_q = 1'b1;
        else begin a_coeff[a_cnt] = c; a_exp[a_cnt] = e; a_cnt++; end
      end
      OP_LOAD_SECOND: begin
        if (b_cnt >= 8) dropped_q = 1'b1;
        else begin b_coeff[b_cnt] = c; b_exp[b_cnt] = e; b_cnt++; end
      end
      OP_CLEAR: begin
        a_cnt = 0; b_cnt = 0; dropped_q = 1'b0;
      end
      default: begin
        if (a_cnt == 0 || b_cnt == 0) begin
          t = '{0, 0, 1'b1, 1'b1, dropped_q};
          pending_terms.push_back(t);
        end else begin
          for (int i = 0; i < a_cnt; i++)
            for (int j = 0; j < b_cnt; j++) begin
              pc = 40'(a_coeff[i]) * 40'(b_coeff[j]);
              pe = 9'(a_exp[i]) + 9'(b_exp[j]);
              pos = 0;
              while (pos < se.size() && se[pos] > pe) pos++;
              if (pos < se.size() && se[pos] == pe) sc[pos] = sc[pos] + pc;
              else begin se.insert(pos, pe); sc.insert(pos, pc); end
            end
          foreach (se[k]) begin
            t = '{sc[k], se[k], k == se.size() - 1, 1'b0, dropped_q};
            pending_terms.push_back(t);
          end
        end
      end
    endcase
  endtask

  task automatic send(input spm_op_e op, input logic signed [15:0] c = 0,
                      input logic [7:0] e = 0);
    while (gaps_on && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {e, c};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict(op, c, e);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_sink) m_axis_tready <= 1'b0;
    else m_axis_tready <= !gaps_on || $urandom_range(99) >= 25;
  end

  always @(posedge clk_i) begin
    term_t t;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_terms.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected term %h", m_axis_tdata);
      end else begin
        t = pending_terms.pop_front();
        if (m_axis_tdata[39:0] !== t.coeff || m_axis_tdata[48:40] !== t.exponent ||
            m_axis_tdata[55:49] !== 7'd0 || m_axis_tlast !== t.last ||
            m_axis_tuser !== {t.dropped, t.empty}) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch exp c=%h e=%h l=%b u=%b%b got d=%h l=%b u=%b",
                     t.coeff, t.exponent, t.last, t.dropped, t.empty,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  task automatic test_directed();
    send(OP_MULTIPLY);
    send(OP_LOAD_FIRST, 16'sh7fff, 8'hff);
    send(OP_MULTIPLY);
    send(OP_LOAD_SECOND, -16'sh8000, 8'hff);
    send(OP_LOAD_SECOND, 16'sh0100, 8'h00);
    send(OP_LOAD_FIRST, -16'sh8000, 8'h00);
    send(OP_MULTIPLY);
    send(OP_MULTIPLY);
    send(OP_LOAD_FIRST, 16'sh0100, 8'h00);
    send(OP_LOAD_SECOND, -16'sh0100, 8'h00);
    send(OP_MULTIPLY);
    send(OP_CLEAR);
    for (int i = 0; i < 9; i++) send(OP_LOAD_FIRST, 16'sh8000 >>> i, 8'(i * 31));
    for (int i = 0; i < 9; i++) send(OP_LOAD_SECOND, 16'sh7fff - i, 8'(255 - i * 17));
    send(OP_MULTIPLY);
    send(OP_CLEAR);
    send(OP_MULTIPLY);
    drain();
  endtask

  task automatic test_random(input int n_sets);
    int na, nb;
    for (int s = 0; s < n_sets; s++) begin
      if (s == n_sets / 2) gaps_on = 1'b0;
      if (s == n_sets * 3 / 4) gaps_on = 1'b1;
      send(OP_CLEAR);
      na = $urandom_range(9); nb = $urandom_range(9);
      for (int i = 0; i < na + nb; i++)
        send($urandom_range(9) < 2 ? spm_op_e'($urandom_range(3)) :
             (i < na ? OP_LOAD_FIRST : OP_LOAD_SECOND),
             $urandom_range(3) == 0 ? 16'($urandom_range(4) << 8) : 16'($urandom),
             $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(7)));
      send(OP_MULTIPLY);
    end
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      begin
        send(OP_CLEAR);
        for (int i = 0; i < 3; i++) send(OP_LOAD_FIRST, 16'($urandom), 8'(i * 5));
        for (int i = 0; i < 3; i++) send(OP_LOAD_SECOND, 16'($urandom), 8'(i));
        for (int i = 0; i < 6; i++) send(OP_MULTIPLY);
        s_axis_tvalid <= 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(25);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_terms.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
